@@ design/sha256_pkg.sv @@
package sha256_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned Rounds = 64;

  // First padding byte and the block position at which the length field starts.
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  localparam logic [0:7][WordW-1:0] H_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic       load;
    logic       start;
    logic       restart;
    logic [7:0] data;
  } core_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;

  function automatic logic [WordW-1:0] bsig0(input logic [WordW-1:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [WordW-1:0] bsig1(input logic [WordW-1:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [WordW-1:0] ssig0(input logic [WordW-1:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [WordW-1:0] ssig1(input logic [WordW-1:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic logic [WordW-1:0] round_k(input logic [5:0] idx);
    logic [WordW-1:0] k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

@@ design/sha256_stream_if.sv @@
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  logic        length_error;

  modport source (output valid, digest_word, word_index, last_word, length_error,
                  input ready);
  modport sink   (input valid, digest_word, word_index, last_word, length_error,
                  output ready);
endinterface

@@ design/sha256_core.sv @@
module sha256_core
  import sha256_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  core_ctrl_t       ctrl_i,
  output core_sts_t        sts_o,
  output logic [0:7][31:0] hash_o
);

  localparam logic [1:0] C_IDLE  = 2'd0;
  localparam logic [1:0] C_ROUND = 2'd1;
  localparam logic [1:0] C_FINAL = 2'd2;

  logic [1:0]       cst_q, cst_d;
  logic [5:0]       rnd_q, rnd_d;
  logic [511:0]     blk_q;
  logic [0:7][31:0] v_q;
  logic [0:7][31:0] h_q;

  logic [31:0] w0, w1, w9, w14, w_new, wt, t1, t2;

  // The block register doubles as the schedule window: word 0 is the oldest.
  always_comb begin
    w0    = blk_q[511:480];
    w1    = blk_q[479:448];
    w9    = blk_q[223:192];
    w14   = blk_q[63:32];
    w_new = ssig1(w14) + w9 + ssig0(w1) + w0;
    wt    = (rnd_q[5:4] == 2'b00) ? w0 : w_new;
    t1    = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
          + round_k(rnd_q) + wt;
    t2    = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  always_comb begin
    cst_d = cst_q;
    rnd_d = rnd_q;
    unique case (cst_q)
      C_IDLE: begin
        if (ctrl_i.start) begin
          cst_d = C_ROUND;
          rnd_d = '0;
        end
      end
      C_ROUND: begin
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'(Rounds - 1)) begin
          cst_d = C_FINAL;
        end
      end
      C_FINAL: cst_d = C_IDLE;
      default: cst_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cst_q <= C_IDLE;
      rnd_q <= '0;
      h_q   <= H_INIT;
    end else begin
      cst_q <= cst_d;
      rnd_q <= rnd_d;
      if (ctrl_i.restart) begin
        h_q <= H_INIT;
      end else if (cst_q == C_FINAL) begin
        for (int i = 0; i < 8; i++) begin
          h_q[i] <= h_q[i] + v_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      blk_q <= {blk_q[503:0], ctrl_i.data};
    end else if (cst_q == C_ROUND) begin
      // Rounds below 16 rotate the loaded words; later rounds append the new word.
      blk_q <= {blk_q[479:0], wt};
    end
    if (ctrl_i.start) begin
      v_q <= h_q;
    end else if (cst_q == C_ROUND) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  assign sts_o.busy = (cst_q != C_IDLE);
  assign sts_o.done = (cst_q == C_FINAL);
  assign hash_o     = h_q;

endmodule

@@ design/sha256_stream_hash_unit.sv @@
// Message bytes are taken one per cycle while idle; every 64th byte starts a compression
// (64 rounds of the round unit plus a final state of chaining adds). An end item pads one
// byte per cycle and compresses one or two blocks; the done state then loads the digest
// buffer, which sends one word a cycle while the sink is ready.
// Input is held off while padding, compressing or waiting for the previous digest to drain.
// Reset (asynchronous, active low) loads the initial hash, clears the count and the output.
module sha256_stream_hash_unit
  import sha256_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  sha256_in_if.sink           in_i,
  sha256_out_if.source        digest_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_COMP  = 3'd1;
  localparam logic [2:0] ST_PAD   = 3'd2;
  localparam logic [2:0] ST_PCOMP = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [31:0] count_q, count_d;
  logic        ovf_q, ovf_d;
  logic [5:0]  fill_q, fill_d;
  logic        endp_q, endp_d;
  logic        padf_q, padf_d;
  logic        lenh_q, lenh_d;

  logic        out_valid_q;
  logic [255:0] dig_q;
  logic [2:0]  idx_q;
  logic        err_q;

  core_ctrl_t       ctrl;
  core_sts_t        sts;
  logic [0:7][31:0] hash;

  logic        in_fire, out_fire, sat, dig_load;
  logic [63:0] len_bits;
  logic [7:0]  len_byte, pad_byte;

  sha256_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .sts_o  (sts),
    .hash_o (hash)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid & in_i.ready;
  assign out_fire   = out_valid_q & digest_o.ready;
  assign sat        = (count_q == '1);

  // The length field is the bit count, big-endian; its bytes sit at positions 56 to 63.
  assign len_bits = {29'd0, count_q, 3'b000};
  assign len_byte = 8'(len_bits >> {~fill_q[2:0], 3'b000});
  assign pad_byte = padf_q ? PAD_MARK :
                    ((lenh_q && fill_q >= LEN_POS) ? len_byte : 8'h00);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ovf_d    = ovf_q;
    fill_d   = fill_q;
    endp_d   = endp_q;
    padf_d   = padf_q;
    lenh_d   = lenh_q;
    ctrl     = '0;
    dig_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.byte_present && sat) begin
            ovf_d = 1'b1;
          end else if (in_i.byte_present) begin
            ctrl.load = 1'b1;
            ctrl.data = in_i.data_byte;
            count_d   = count_q + 32'd1;
            fill_d    = fill_q + 6'd1;
          end
          if (ctrl.load && fill_q == '1) begin
            ctrl.start = 1'b1;
            endp_d     = in_i.end_of_message;
            state_d    = ST_COMP;
          end else if (in_i.end_of_message) begin
            padf_d  = 1'b1;
            state_d = ST_PAD;
          end
        end
      end
      ST_COMP: begin
        if (sts.done) begin
          state_d = endp_q ? ST_PAD : ST_IDLE;
          padf_d  = endp_q;
          endp_d  = 1'b0;
        end
      end
      ST_PAD: begin
        ctrl.load = 1'b1;
        ctrl.data = pad_byte;
        fill_d    = fill_q + 6'd1;
        padf_d    = 1'b0;
        // The marker byte leaves room for the length in this block only below position 56.
        if (padf_q && fill_q < LEN_POS) begin
          lenh_d = 1'b1;
        end
        if (fill_q == '1) begin
          ctrl.start = 1'b1;
          state_d    = ST_PCOMP;
        end
      end
      ST_PCOMP: begin
        if (sts.done) begin
          if (lenh_q) begin
            state_d = ST_DONE;
          end else begin
            lenh_d  = 1'b1;
            state_d = ST_PAD;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q) begin
          dig_load     = 1'b1;
          ctrl.restart = 1'b1;
          count_d      = '0;
          ovf_d        = 1'b0;
          lenh_d       = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      ovf_q   <= 1'b0;
      fill_q  <= '0;
      endp_q  <= 1'b0;
      padf_q  <= 1'b0;
      lenh_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      fill_q  <= fill_d;
      endp_q  <= endp_d;
      padf_q  <= padf_d;
      lenh_q  <= lenh_d;
    end
  end

  // Digest buffer: frees the core for the next message while the words drain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (dig_load) begin
      out_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (out_fire) begin
      out_valid_q <= (idx_q != 3'd7);
      idx_q       <= idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dig_load) begin
      dig_q <= hash;
      err_q <= ovf_q;
    end else if (out_fire) begin
      dig_q <= {dig_q[223:0], 32'd0};
    end
  end

  assign digest_o.valid        = out_valid_q;
  assign digest_o.digest_word  = dig_q[255:224];
  assign digest_o.word_index   = idx_q;
  assign digest_o.last_word    = (idx_q == 3'd7);
  assign digest_o.length_error = err_q;

  a_idle_core_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !sts.busy)
    else $error("input open while the compression core is busy");

  a_start_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.start |-> !sts.busy)
    else $error("compression started while the core is busy");

  a_block_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMP || state_q == ST_PCOMP) |-> (fill_q == '0))
    else $error("compression running on a partly filled block");

  a_word_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && idx_q != 3'd7) |=> (out_valid_q && idx_q == $past(idx_q) + 3'd1))
    else $error("digest words out of order");

endmodule
